@@ sv/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and codes for the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

	// default number of slots in the ring
	localparam int DQ_DEPTH = 16;

	// field widths of one item
	localparam int KIND_W  = 3;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;

	// operation codes
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_POP_FRONT  = 3'd1,
		KIND_PEEK_FRONT = 3'd2,
		KIND_PUSH_BACK  = 3'd3,
		KIND_POP_BACK   = 3'd4,
		KIND_PEEK_BACK  = 3'd5
	} op_kind_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} op_status_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [STAT_W-1:0]         status;
		logic [OCC_W-1:0]          occupancy;
	} out_item_t;

	// controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RESP
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;   // item taken this cycle: run the operation
		logic load;     // move the finished result into the output register
	} dq_cmd_t;

endpackage

@@ sv/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// deque of signed 32-bit values held in a ring store with front/back pointers
// ----------------------------------------------------------------------------
//
//  channel   signals                         carries
//  -------   -----------------------------   ---------------------------------
//  input     in_valid, in_ready, in_data     kind, push_value
//  output    out_valid, out_ready, out_data  read_value, status, occupancy
//
// the accept edge of an item writes the ring or registers the read; in
// the response state the result moves into the output register as soon
// as that is free or being emptied; only then can a new item be taken
// a result left waiting on out_ready still lets one more item in; that item
// then holds the block in its response state until the result is taken
// reset (arst_n low) empties the queue; the ring contents are not cleared
// and are never read before a push has written them
//
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	// commands from the handshake controller to the ring datapath
	dq_cmd_t cmd;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// pointers wrap at DEPTH, occupancy reports the low bits of the count
	dq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

@@ sv/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl
// handshake controller: takes one item, waits for the output register, hands on
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dq_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				// output register free or being emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// dq_datapath
// ring store, front/back pointers, entry count and result register
// ----------------------------------------------------------------------------
module dq_datapath import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dq_cmd_t   cmd,
	input  in_item_t  in_data,
	output out_item_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic signed [VALUE_W-1:0] mem [DEPTH];

	logic [AW-1:0] front_q, back_q, front_d, back_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] front_prev, front_next, back_prev, back_next;
	logic [AW-1:0] addr;
	logic          wr_en, rd_hit;
	op_status_t    stat;

	logic signed [VALUE_W-1:0] rdata_q;
	logic                      rd_hit_q;
	op_status_t                stat_q;
	logic [CW+OCC_W-1:0]       occ_ext;
	logic [OCC_W-1:0]          occ_q;
	out_item_t                 out_q;

	// wrapping neighbours of both pointers
	assign front_prev = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
	assign front_next = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
	assign back_prev  = (back_q == '0) ? LAST_SLOT : back_q - 1'b1;
	assign back_next  = (back_q == LAST_SLOT) ? '0 : back_q + 1'b1;

	always_comb begin
		front_d = front_q;
		back_d  = back_q;
		count_d = count_q;
		addr    = front_q;
		wr_en   = 1'b0;
		rd_hit  = 1'b0;
		stat    = STATUS_OK;
		unique case (in_data.kind) inside
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (count_q == FULL_COUNT) begin
					stat = STATUS_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
					if (in_data.kind == KIND_PUSH_FRONT) begin
						addr    = front_prev;
						front_d = front_prev;
					end else begin
						addr   = back_q;
						back_d = back_next;
					end
				end
			end
			KIND_POP_FRONT, KIND_PEEK_FRONT: begin
				if (count_q == '0) begin
					stat = STATUS_EMPTY;
				end else begin
					rd_hit = 1'b1;
					addr   = front_q;
					if (in_data.kind == KIND_POP_FRONT) begin
						front_d = front_next;
						count_d = count_q - 1'b1;
					end
				end
			end
			KIND_POP_BACK, KIND_PEEK_BACK: begin
				if (count_q == '0) begin
					stat = STATUS_EMPTY;
				end else begin
					rd_hit = 1'b1;
					addr   = back_prev;
					if (in_data.kind == KIND_POP_BACK) begin
						back_d  = back_prev;
						count_d = count_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign occ_ext = {{OCC_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	// store: at most one write and one registered read per item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (wr_en) begin
				mem[addr] <= in_data.push_value;
			end
			rdata_q  <= mem[addr];
			rd_hit_q <= rd_hit;
			stat_q   <= stat;
			occ_q    <= occ_ext[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.read_value <= rd_hit_q ? rdata_q : '0;
			out_q.status     <= stat_q;
			out_q.occupancy  <= occ_q;
		end
	end

	assign out_data = out_q;

endmodule

@@ tb/double_ended_queue_tb.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// self-checking bench for the ring-buffer double-ended queue
// ----------------------------------------------------------------------------
// items are sent on the input channel and the expected result of each is
// worked out by a behavioural deque model when the item is accepted
// a receive process takes every result and checks it against the oldest
// expected result
// directed cases cover the empty and full queue, the front pointer wrap,
// the value extremes and the unused operation codes
// a long random run follows, in phases biased towards pushes or pops or balanced
// both sides insert random idle cycles, with some phases run at full rate
// ----------------------------------------------------------------------------
module double_ended_queue_tb import dq_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	// codes outside the defined operations: the block treats them as no-ops
	localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_WAIT     = 19;
	localparam int REPORT_MAX   = 10;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	// behavioural copy of the queue state
	logic signed [VALUE_W-1:0] model_ring [DQ_DEPTH];
	int unsigned               model_front;
	int unsigned               model_back;
	int unsigned               model_count;

	// results still owed by the block, oldest first
	out_item_t awaited_results [$];

	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned stray_count;

	// idle-cycle switches for each side
	bit send_idles;
	bit recv_idles;

	double_ended_queue #(
		.DEPTH(DQ_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// deque model: applies one operation and returns the expected result
	// ------------------------------------------------------------------
	function automatic out_item_t deque_predict(in_item_t item);
		out_item_t   res;
		int unsigned slot;
		res.read_value = '0;
		res.status     = STATUS_OK;
		case (item.kind)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (model_count >= DQ_DEPTH) begin
					// full: item dropped
					res.status = STATUS_FULL;
				end else if (item.kind == KIND_PUSH_FRONT) begin
					model_front = (model_front == 0) ? DQ_DEPTH - 1 : model_front - 1;
					model_ring[model_front] = item.push_value;
					model_count++;
				end else begin
					model_ring[model_back] = item.push_value;
					model_back = (model_back + 1 >= DQ_DEPTH) ? 0 : model_back + 1;
					model_count++;
				end
			end
			KIND_POP_FRONT, KIND_PEEK_FRONT: begin
				if (model_count == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					res.read_value = model_ring[model_front];
					if (item.kind == KIND_POP_FRONT) begin
						model_front = (model_front + 1 >= DQ_DEPTH) ? 0 : model_front + 1;
						model_count--;
					end
				end
			end
			KIND_POP_BACK, KIND_PEEK_BACK: begin
				if (model_count == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					slot = (model_back == 0) ? DQ_DEPTH - 1 : model_back - 1;
					res.read_value = model_ring[slot];
					if (item.kind == KIND_POP_BACK) begin
						model_back = slot;
						model_count--;
					end
				end
			end
			default: begin
				// unused code: nothing happens
			end
		endcase
		res.occupancy = model_count[OCC_W-1:0];
		return res;
	endfunction

	function automatic int draw_wait(bit enabled);
		return enabled ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	// ------------------------------------------------------------------
	// send one item; valid stays high into the next item when no gap
	// ------------------------------------------------------------------
	task automatic send_item(logic [KIND_W-1:0] kind,
			logic signed [VALUE_W-1:0] value);
		in_item_t item;
		int       gap;
		item.kind       = kind;
		item.push_value = value;
		gap = draw_wait(send_idles);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge
		awaited_results.push_back(deque_predict(item));
	endtask

	// ------------------------------------------------------------------
	// receive side: takes every result and checks it against the model
	// ------------------------------------------------------------------
	initial begin : receiver
		out_item_t got;
		out_item_t want;
		int        stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(recv_idles);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = out_data;
			if (awaited_results.size() == 0) begin
				stray_count++;
				if (stray_count + mismatch_count <= REPORT_MAX)
					$display("unexpected result: value %0d status %0d occupancy %0d",
						got.read_value, got.status, got.occupancy);
			end else begin
				want = awaited_results.pop_front();
				if (got.read_value !== want.read_value || got.status !== want.status ||
						got.occupancy !== want.occupancy) begin
					mismatch_count++;
					if (stray_count + mismatch_count <= REPORT_MAX)
						$display("mismatch: value exp %0d got %0d, %s %0d got %0d, %s %0d got %0d",
							want.read_value, got.read_value,
							"status exp", want.status, got.status,
							"occupancy exp", want.occupancy, got.occupancy);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// directed: operations on an empty queue
	// ------------------------------------------------------------------
	task automatic test_empty_queue();
		send_item(KIND_POP_FRONT, 32'sd1);
		send_item(KIND_PEEK_BACK, -32'sd1);
		send_item(KIND_POP_BACK, 32'sd0);
		send_item(KIND_PEEK_FRONT, 32'sh7fff_ffff);
		send_item(KIND_UNUSED_6, 32'sh1234_5678);
	endtask

	// ------------------------------------------------------------------
	// directed: fill from both ends (the front pointer wraps below slot 0),
	// push when full, then read
	// ------------------------------------------------------------------
	task automatic test_fill_to_full();
		logic signed [VALUE_W-1:0] extremes [4];
		int i;
		extremes[0] = 32'sh8000_0000;
		extremes[1] = 32'sh7fff_ffff;
		extremes[2] = 32'sh0000_0000;
		extremes[3] = 32'shffff_ffff;
		for (i = 0; i < DQ_DEPTH; i++) begin
			if (i % 2 == 0)
				send_item(KIND_PUSH_FRONT, (i < 8) ? extremes[i % 4] : $urandom);
			else
				send_item(KIND_PUSH_BACK, (i < 8) ? extremes[i % 4] : $urandom);
		end
		// full: both pushes dropped
		send_item(KIND_PUSH_FRONT, 32'sh5555_5555);
		send_item(KIND_PUSH_BACK, 32'shaaaa_aaaa);
		send_item(KIND_UNUSED_7, 32'shdead_beef);
		send_item(KIND_PEEK_FRONT, 32'sd0);
		send_item(KIND_PEEK_BACK, 32'sd0);
		send_item(KIND_POP_FRONT, 32'sd0);
		send_item(KIND_POP_BACK, 32'sd0);
	endtask

	// ------------------------------------------------------------------
	// random: phases biased towards pushes or pops, or balanced, so the queue keeps
	// swinging between empty and full, with idling switched per phase
	// ------------------------------------------------------------------
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sh0000_0000;
			3:       return 32'shffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return $urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
		if (roll < 2 + push_pct)
			return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		case ($urandom_range(0, 5))
			0, 1:    return KIND_POP_FRONT;
			2, 3:    return KIND_POP_BACK;
			4:       return KIND_PEEK_FRONT;
			default: return KIND_PEEK_BACK;
		endcase
	endfunction

	task automatic test_random_ops();
		int sent;
		int phase_len;
		int push_pct;
		int i;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len  = $urandom_range(40, 80);
			case ($urandom_range(0, 2))
				0:       push_pct = 15;
				1:       push_pct = 50;
				default: push_pct = 85;
			endcase
			send_idles = ($urandom_range(0, 3) != 0);
			recv_idles = ($urandom_range(0, 3) != 0);
			for (i = 0; i < phase_len; i++)
				send_item(pick_kind(push_pct), pick_value());
			sent += phase_len;
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : main
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		cycle_count    = 0;
		mismatch_count = 0;
		stray_count    = 0;
		send_idles     = 1'b1;
		recv_idles     = 1'b1;
		model_front    = 0;
		model_back     = 0;
		model_count    = 0;
		foreach (model_ring[i]) model_ring[i] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_fill_to_full();
		test_random_ops();

		// drain, then wait for any stray result
		in_valid <= 1'b0;
		recv_idles = 1'b1;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && stray_count == 0 && awaited_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
